[hdl/lrj_pkg.sv]
// ----------------------------------------------------------------------------
// Logistic residual and gradient unit: shared package
// Types, constants and helper functions used across the pipeline.
// ----------------------------------------------------------------------------
package lrj_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int HORNER_TERMS  = 10;
    localparam int SP_BITS       = 31;

    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [16:0] GH_MAX    = 17'h1FFFF;

    localparam logic [1:0] REG_CURVE_HEIGHT = 2'd0;
    localparam logic [1:0] REG_STEEPNESS    = 2'd1;
    localparam logic [1:0] REG_MIDPOINT     = 2'd2;

    typedef struct packed {
        logic        tneg;
        logic        fneg;
        logic        gk_neg;
        logic        gx_neg;
        logic [31:0] y;
        logic [31:0] ml;
        logic [63:0] m_ld;
        logic [63:0] m_lk;
    } t_side;

    typedef struct packed {
        logic [31:0] r;
        logic [5:0]  n;
        t_side       side;
    } t_exp;

    typedef struct packed {
        logic [32:0] p;
        logic [5:0]  n;
        t_side       side;
    } t_dvd;

    typedef struct packed {
        logic [SP_BITS-1:0] sp;
        t_side              side;
    } t_quo;

    typedef struct packed {
        logic [31:0] model_value;
        logic [31:0] residual;
        logic [16:0] grad_height;
        logic [31:0] grad_steepness;
        logic [31:0] grad_midpoint;
        logic        saturated;
    } t_result;

    // Reciprocal of j scaled so that (t * mul) >> shr equals t / j for any 32-bit t.
    function automatic logic [32:0] horner_mul(input int j);
        logic [32:0] m;
        unique case (j)
            3:       m = 33'd5726623062;
            5:       m = 33'd6871947674;
            6:       m = 33'd5726623062;
            7:       m = 33'd4908534053;
            9:       m = 33'd7635497416;
            10:      m = 33'd6871947674;
            default: m = ONE_Q32;
        endcase
        return m;
    endfunction

    function automatic int horner_shr(input int j);
        int s;
        unique case (j)
            1:       s = 32;
            2:       s = 33;
            3, 4:    s = 34;
            5, 6, 7, 8: s = 35;
            default: s = 36;
        endcase
        return s;
    endfunction

    // Bit 32 is the clamp flag, bits 31:0 the clamped value.
    function automatic logic [32:0] sat_q(input logic signed [63:0] v);
        logic [32:0] res;
        if (v > 64'sh7FFF_FFFF) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sh8000_0000) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

[hdl/lrj_if.sv]
// ----------------------------------------------------------------------------
// Logistic residual and gradient unit: channel interfaces
// Sample, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lrj_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;

    modport source (output valid, sample_x, sample_y, input ready);
    modport sink (input valid, sample_x, sample_y, output ready);
endinterface

interface lrj_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] model_value;
    logic signed [31:0] residual;
    logic        [16:0] grad_height;
    logic signed [31:0] grad_steepness;
    logic signed [31:0] grad_midpoint;
    logic               saturated;

    modport source (output valid, model_value, residual, grad_height, grad_steepness,
                    grad_midpoint, saturated, input ready);
    modport sink (input valid, model_value, residual, grad_height, grad_steepness,
                  grad_midpoint, saturated, output ready);
endinterface

interface lrj_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/logistic_residual_jacobian_unit.sv]
// ----------------------------------------------------------------------------
// Logistic residual and gradient unit: top level
// Evaluates L/(1+exp(-k(x-x0))), its residual against y and the gradients.
// ----------------------------------------------------------------------------
// The sample channel takes one (x, y) pair per transfer and the result channel
// gives one result per sample, in order. The register channel is always ready
// and writes height, steepness or midpoint; writes to other indexes are dropped.
// Registers should change only while no sample is in flight.
// A sample may be transferred in every cycle in which ready is high. The depth of
// the pipeline comes from ten Horner terms of two stages each and a divider that
// resolves one quotient bit per stage.
// The result sits in an output register backed by one skid register. When the
// receiver stalls, one more result lands in the skid register and the sample
// channel then drops ready until the skid register drains; nothing in flight
// is lost or repeated.
// Reset clears all valid bits and loads height 1.0, steepness 1.0, midpoint 0.
// ----------------------------------------------------------------------------
module logistic_residual_jacobian_unit
    import lrj_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lrj_sample_if.sink    i_sample,
    lrj_cfg_if.sink       i_cfg,
    lrj_result_if.source  o_result
);

    logic    w_en;
    logic    w_f_valid;
    t_exp    w_f_data;
    logic    w_e_valid;
    t_dvd    w_e_data;
    logic    w_d_valid;
    t_quo    w_d_data;
    logic    w_b_valid;
    t_result w_b_data;

    logic [31:0] r_height;
    logic [31:0] r_steep;
    logic [31:0] r_mid;
    logic        r_out_valid;
    logic        r_skid_valid;
    t_result     r_out;
    t_result     r_skid;

    assign w_en           = !r_skid_valid;
    assign i_sample.ready = w_en;
    assign i_cfg.ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= 32'd65536;
            r_steep  <= 32'd65536;
            r_mid    <= 32'd0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_CURVE_HEIGHT: r_height <= i_cfg.data;
                REG_STEEPNESS:    r_steep  <= i_cfg.data;
                REG_MIDPOINT:     r_mid    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    lrj_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_sample.valid),
        .i_sample_x (i_sample.sample_x),
        .i_sample_y (i_sample.sample_y),
        .i_height   (r_height),
        .i_steep    (r_steep),
        .i_mid      (r_mid),
        .o_valid    (w_f_valid),
        .o_data     (w_f_data)
    );

    lrj_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_data  (w_f_data),
        .o_valid (w_e_valid),
        .o_data  (w_e_data)
    );

    lrj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_e_valid),
        .i_data  (w_e_data),
        .o_valid (w_d_valid),
        .o_data  (w_d_data)
    );

    lrj_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_data  (w_d_data),
        .o_valid (w_b_valid),
        .o_data  (w_b_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_result.ready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || o_result.ready) begin
            r_out_valid <= w_b_valid;
        end else if (w_b_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (o_result.ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || o_result.ready) begin
            r_out <= w_b_data;
        end else begin
            r_skid <= w_b_data;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.model_value    = r_out.model_value;
    assign o_result.residual       = r_out.residual;
    assign o_result.grad_height    = r_out.grad_height;
    assign o_result.grad_steepness = r_out.grad_steepness;
    assign o_result.grad_midpoint  = r_out.grad_midpoint;
    assign o_result.saturated      = r_out.saturated;

`ifndef ASSERT_OFF
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_skid_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_result.ready))
        else $error("skid register filled without a stalled output");

    a_height_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready && i_cfg.index == REG_CURVE_HEIGHT)
        |=> (r_height == $past(i_cfg.data)))
        else $error("height register write was not taken");
`endif

endmodule

[hdl/lrj_front.sv]
// ----------------------------------------------------------------------------
// Logistic residual and gradient unit: front end
// Forms x - x0, the magnitude products and the exponent argument.
// ----------------------------------------------------------------------------
module lrj_front
    import lrj_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_sample_x,
    input  logic [31:0] i_sample_y,
    input  logic [31:0] i_height,
    input  logic [31:0] i_steep,
    input  logic [31:0] i_mid,
    output logic        o_valid,
    output t_exp        o_data
);

    localparam int U_W = FRAC_BITS + 6;
    localparam int V_W = U_W + 33;
    localparam logic [U_W-1:0] U_MAX  = U_W'(32) << FRAC_BITS;
    localparam logic [63:0]    U_HALF = 64'd1 << (FRAC_BITS - 1);

    logic [32:0]    w_d;
    logic [32:0]    w_md;
    logic [31:0]    w_mk;
    logic [31:0]    w_ml;
    logic           w_kneg;
    logic           w_kzero;
    logic           w_dneg;
    logic           w_dzero;
    logic           w_lneg;
    logic           w_lzero;
    t_side          w_side;
    t_side          w_side_p;
    logic [64:0]    w_pu;
    logic [64:0]    w_pld;
    logic [63:0]    w_plk;
    logic [63:0]    w_ur;
    logic [63:0]    w_us;
    logic [V_W-1:0] w_vp;
    logic [V_W-1:0] w_vs;
    logic [63:0]    w_rp;

    logic [4:0]     r_v;
    logic [32:0]    r1_md;
    logic [31:0]    r1_mk;
    t_side          r1_side;
    logic [63:0]    r2_pu;
    t_side          r2_side;
    logic [U_W-1:0] r3_u;
    t_side          r3_side;
    logic [37:0]    r4_v;
    t_side          r4_side;
    t_exp           r5;

    always_comb begin
        w_d     = {i_sample_x[31], i_sample_x} - {i_mid[31], i_mid};
        w_dneg  = w_d[32];
        w_dzero = (w_d == 33'd0);
        w_md    = w_dneg ? (33'd0 - w_d) : w_d;
        w_kneg  = i_steep[31];
        w_kzero = (i_steep == 32'd0);
        w_mk    = w_kneg ? (32'd0 - i_steep) : i_steep;
        w_lneg  = i_height[31];
        w_lzero = (i_height == 32'd0);
        w_ml    = w_lneg ? (32'd0 - i_height) : i_height;

        w_side        = '0;
        w_side.tneg   = (w_kneg && !w_dneg && !w_dzero) || (!w_kneg && !w_kzero && w_dneg);
        w_side.fneg   = w_lneg;
        w_side.gk_neg = (w_lneg != w_dneg) && !w_lzero && !w_dzero;
        w_side.gx_neg = (w_lneg == w_kneg) && !w_lzero && !w_kzero;
        w_side.y      = i_sample_y;
        w_side.ml     = w_ml;
    end

    assign w_pu  = 65'(r1_mk) * 65'(r1_md);
    assign w_pld = 65'(r1_side.ml) * 65'(r1_md);
    assign w_plk = 64'(r1_side.ml) * 64'(r1_mk);
    assign w_ur  = r2_pu + U_HALF;
    assign w_us  = w_ur >> FRAC_BITS;
    assign w_vp  = V_W'(r3_u) * V_W'(LOG2E_Q32);
    assign w_vs  = w_vp >> FRAC_BITS;
    assign w_rp  = 64'(r4_v[31:0]) * 64'(LN2_Q32);

    always_comb begin
        w_side_p      = r1_side;
        w_side_p.m_ld = w_pld[63:0];
        w_side_p.m_lk = w_plk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_md   <= w_md;
            r1_mk   <= w_mk;
            r1_side <= w_side;
            r2_pu   <= w_pu[63:0];
            r2_side <= w_side_p;
            r3_u    <= (w_us > 64'(U_MAX)) ? U_MAX : w_us[U_W-1:0];
            r3_side <= r2_side;
            r4_v    <= w_vs[37:0];
            r4_side <= r3_side;
            r5      <= '{r: w_rp[63:32], n: r4_v[37:32], side: r4_side};
        end
    end

    assign o_valid = r_v[4];
    assign o_data  = r5;

endmodule

[hdl/lrj_exp.sv]
// ----------------------------------------------------------------------------
// Logistic residual and gradient unit: exponential
// Horner series for exp(-r) in Q32, two register stages per term.
// ----------------------------------------------------------------------------
module lrj_exp
    import lrj_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_exp i_data,
    output logic o_valid,
    output t_dvd o_data
);

    logic [32:0] w_p [0:HORNER_TERMS];
    t_exp        w_x [0:HORNER_TERMS];
    logic        w_v [0:HORNER_TERMS];

    assign w_p[0] = ONE_Q32;
    assign w_x[0] = i_data;
    assign w_v[0] = i_valid;

    for (genvar g = 0; g < HORNER_TERMS; g++) begin : g_term
        localparam int          J   = HORNER_TERMS - g;
        localparam logic [32:0] MUL = horner_mul(J);
        localparam int          SHR = horner_shr(J);

        logic [64:0] w_rp;
        logic [64:0] w_tq;
        logic [64:0] w_q;
        logic [31:0] r_t;
        t_exp        r_tx;
        logic        r_tv;
        logic [32:0] r_p;
        t_exp        r_px;
        logic        r_pv;

        assign w_rp = 65'(w_x[g].r) * 65'(w_p[g]);
        assign w_tq = 65'(r_t) * 65'(MUL);
        assign w_q  = w_tq >> SHR;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tv <= 1'b0;
                r_pv <= 1'b0;
            end else if (i_en) begin
                r_tv <= w_v[g];
                r_pv <= r_tv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t  <= w_rp[63:32];
                r_tx <= w_x[g];
                r_p  <= ONE_Q32 - w_q[32:0];
                r_px <= r_tx;
            end
        end

        assign w_p[g+1] = r_p;
        assign w_x[g+1] = r_px;
        assign w_v[g+1] = r_pv;
    end

    assign o_valid     = w_v[HORNER_TERMS];
    assign o_data.p    = w_p[HORNER_TERMS];
    assign o_data.n    = w_x[HORNER_TERMS].n;
    assign o_data.side = w_x[HORNER_TERMS].side;

endmodule

[hdl/lrj_div.sv]
// ----------------------------------------------------------------------------
// Logistic residual and gradient unit: sigmoid divider
// Forms 1 + exp(-|t|) and divides it into one, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lrj_div
    import lrj_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_dvd i_data,
    output logic o_valid,
    output t_quo o_data
);

    logic [32:0]        w_e;
    logic [33:0]        w_den;
    logic [62:0]        w_num;

    logic [33:0]        w_rem  [0:SP_BITS];
    logic [SP_BITS-1:0] w_low  [0:SP_BITS];
    logic [33:0]        w_dv   [0:SP_BITS];
    logic [SP_BITS-1:0] w_quo  [0:SP_BITS];
    t_side              w_side [0:SP_BITS];
    logic               w_v    [0:SP_BITS];

    logic [33:0]        r0_rem;
    logic [SP_BITS-1:0] r0_low;
    logic [33:0]        r0_den;
    t_side              r0_side;
    logic               r0_v;

    assign w_e   = i_data.p >> i_data.n;
    assign w_den = {1'b0, ONE_Q32} + {1'b0, w_e};
    assign w_num = {1'b1, 62'd0} + 63'(w_den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_rem  <= {2'b00, w_num[62:SP_BITS]};
            r0_low  <= w_num[SP_BITS-1:0];
            r0_den  <= w_den;
            r0_side <= i_data.side;
        end
    end

    assign w_rem[0]  = r0_rem;
    assign w_low[0]  = r0_low;
    assign w_dv[0]   = r0_den;
    assign w_quo[0]  = '0;
    assign w_side[0] = r0_side;
    assign w_v[0]    = r0_v;

    for (genvar g = 0; g < SP_BITS; g++) begin : g_bit
        localparam int B = SP_BITS - 1 - g;

        logic [34:0]        w_r2;
        logic [34:0]        w_diff;
        logic               w_ge;
        logic [33:0]        r_rem;
        logic [SP_BITS-1:0] r_low;
        logic [33:0]        r_den;
        logic [SP_BITS-1:0] r_quo;
        t_side              r_side;
        logic               r_v;

        assign w_r2   = {w_rem[g], w_low[g][B]};
        assign w_diff = w_r2 - {1'b0, w_dv[g]};
        assign w_ge   = (w_r2 >= {1'b0, w_dv[g]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? w_diff[33:0] : w_r2[33:0];
                r_low  <= w_low[g];
                r_den  <= w_dv[g];
                r_quo  <= {w_quo[g][SP_BITS-2:0], w_ge};
                r_side <= w_side[g];
            end
        end

        assign w_rem[g+1]  = r_rem;
        assign w_low[g+1]  = r_low;
        assign w_dv[g+1]   = r_den;
        assign w_quo[g+1]  = r_quo;
        assign w_side[g+1] = r_side;
        assign w_v[g+1]    = r_v;
    end

    assign o_valid     = w_v[SP_BITS];
    assign o_data.sp   = w_quo[SP_BITS];
    assign o_data.side = w_side[SP_BITS];

endmodule

[hdl/lrj_back.sv]
// ----------------------------------------------------------------------------
// Logistic residual and gradient unit: back end
// Scales the sigmoid into the model value, residual and gradients.
// ----------------------------------------------------------------------------
module lrj_back
    import lrj_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_quo    i_data,
    output logic    o_valid,
    output t_result o_data
);

    localparam logic [31:0] GH_HALF = 32'd1 << (29 - FRAC_BITS);
    localparam logic [63:0] G_RND   = 64'd1 << (FRAC_BITS - 3);

    logic [SP_BITS-1:0] w_s;
    logic [61:0]        w_qp;
    logic [62:0]        w_fp;
    logic [31:0]        w_ghs;
    logic [31:0]        w_gh;
    logic [61:0]        w_q;
    logic [62:0]        w_fm;
    logic signed [33:0] w_fval;
    logic signed [33:0] w_res;
    logic [60:0]        w_a_ld;
    logic [60:0]        w_b_ld;
    logic [60:0]        w_a_lk;
    logic [60:0]        w_b_lk;
    logic [63:0]        w_h_ld;
    logic [63:0]        w_h_lk;
    logic [63:0]        w_m_ld;
    logic [63:0]        w_m_lk;
    logic signed [63:0] w_g_ld;
    logic signed [63:0] w_g_lk;
    logic [32:0]        w_sat_f;
    logic [32:0]        w_sat_r;
    logic [32:0]        w_sat_k;
    logic [32:0]        w_sat_x;

    logic [3:0]         r_v;
    logic [61:0]        r1_qp;
    logic [62:0]        r1_fp;
    logic [16:0]        r1_gh;
    logic               r1_sat;
    t_side              r1_side;
    logic [28:0]        r2_q;
    logic [31:0]        r2_fm;
    logic [16:0]        r2_gh;
    logic               r2_sat;
    t_side              r2_side;
    logic signed [33:0] r3_fval;
    logic signed [33:0] r3_res;
    logic [60:0]        r3_a_ld;
    logic [60:0]        r3_b_ld;
    logic [60:0]        r3_a_lk;
    logic [60:0]        r3_b_lk;
    logic [16:0]        r3_gh;
    logic               r3_sat;
    logic               r3_gk_neg;
    logic               r3_gx_neg;
    t_result            r4;

    assign w_s   = i_data.side.tneg ? (ONE_Q30 - i_data.sp) : i_data.sp;
    assign w_qp  = 62'(i_data.sp) * 62'(ONE_Q30 - i_data.sp);
    assign w_fp  = 63'(i_data.side.ml) * 63'(w_s);
    assign w_ghs = 32'(w_s) + GH_HALF;
    assign w_gh  = w_ghs >> (30 - FRAC_BITS);

    assign w_q  = (r1_qp + (62'd1 << 29)) >> 30;
    assign w_fm = (r1_fp + (63'd1 << 29)) >> 30;

    assign w_fval = r2_side.fneg ? (34'sd0 - $signed({2'b00, r2_fm}))
                                 : $signed({2'b00, r2_fm});
    assign w_res  = w_fval - $signed({{2{r2_side.y[31]}}, r2_side.y});
    assign w_a_ld = 61'(r2_side.m_ld[63:32]) * 61'(r2_q);
    assign w_b_ld = 61'(r2_side.m_ld[31:0]) * 61'(r2_q);
    assign w_a_lk = 61'(r2_side.m_lk[63:32]) * 61'(r2_q);
    assign w_b_lk = 61'(r2_side.m_lk[31:0]) * 61'(r2_q);

    assign w_h_ld  = 64'(r3_a_ld) + 64'(r3_b_ld >> 32) + G_RND;
    assign w_h_lk  = 64'(r3_a_lk) + 64'(r3_b_lk >> 32) + G_RND;
    assign w_m_ld  = w_h_ld >> (FRAC_BITS - 2);
    assign w_m_lk  = w_h_lk >> (FRAC_BITS - 2);
    assign w_g_ld  = r3_gk_neg ? -$signed(w_m_ld) : $signed(w_m_ld);
    assign w_g_lk  = r3_gx_neg ? -$signed(w_m_lk) : $signed(w_m_lk);
    assign w_sat_f = sat_q(64'(r3_fval));
    assign w_sat_r = sat_q(64'(r3_res));
    assign w_sat_k = sat_q(w_g_ld);
    assign w_sat_x = sat_q(w_g_lk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_qp   <= w_qp;
            r1_fp   <= w_fp;
            r1_gh   <= (w_gh > 32'(GH_MAX)) ? GH_MAX : w_gh[16:0];
            r1_sat  <= (w_gh > 32'(GH_MAX));
            r1_side <= i_data.side;

            r2_q    <= w_q[28:0];
            r2_fm   <= w_fm[31:0];
            r2_gh   <= r1_gh;
            r2_sat  <= r1_sat;
            r2_side <= r1_side;

            r3_fval   <= w_fval;
            r3_res    <= w_res;
            r3_a_ld   <= w_a_ld;
            r3_b_ld   <= w_b_ld;
            r3_a_lk   <= w_a_lk;
            r3_b_lk   <= w_b_lk;
            r3_gh     <= r2_gh;
            r3_sat    <= r2_sat;
            r3_gk_neg <= r2_side.gk_neg;
            r3_gx_neg <= r2_side.gx_neg;

            r4 <= '{model_value:    w_sat_f[31:0],
                    residual:       w_sat_r[31:0],
                    grad_height:    r3_gh,
                    grad_steepness: w_sat_k[31:0],
                    grad_midpoint:  w_sat_x[31:0],
                    saturated:      r3_sat | w_sat_f[32] | w_sat_r[32] | w_sat_k[32]
                                    | w_sat_x[32]};
        end
    end

    assign o_valid = r_v[3];
    assign o_data  = r4;

endmodule
